@@ design/mvst_pkg.sv @@
// Shared widths, register indexes and reset values of the MPPT tracker.
package mvst_pkg;

	localparam int VOLT_W   = 16;
	localparam int CURR_W   = 16;
	localparam int PWR_W    = 32;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// scaled |dP| (|dP| times 40 at most) and its product with the gain
	localparam int DPM_W    = PWR_W + 6;
	localparam int NUM_W    = DPM_W + CFG_W;
	// |dV| * 2560 fits in 28 bits
	localparam int DEN_W    = VOLT_W + 12;
	// quotient bits kept; anything larger saturates to step_max anyway
	localparam int QUO_W    = CFG_W;
	// signed setpoint sum before clamping
	localparam int SP_W     = VOLT_W + 2;

	localparam logic [PWR_W-1:0] DP_THRESHOLD_UW = PWR_W'(20000);

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_BASE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MAX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_RES      = 2'd3;

	localparam logic [CFG_W-1:0] GAIN_BASE_RST      = 16'd256;
	localparam logic [CFG_W-1:0] SETPOINT_MAX_RST   = 16'd65535;
	localparam logic [CFG_W-1:0] STEP_MAX_RST       = 16'd500;
	localparam logic [CFG_W-1:0] SLOPE_RES_RST      = 16'd10;

endpackage

@@ design/mvst_ser_mul.sv @@
// Bit-serial shift-add unsigned multiplier, one multiplier bit per cycle.
module mvst_ser_mul #(
	parameter int A_W = 16,
	parameter int B_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);

	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]   a_q;
	logic [P_W-1:0]   prod_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [A_W:0]     sum;

	// add the multiplicand into the high half when the low bit is set
	assign sum = {1'b0, prod_q[P_W-1:B_W]} + (prod_q[0] ? {1'b0, a_q} : {(A_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(B_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{A_W{1'b0}}, b};
		end else if (run_q) begin
			prod_q <= {sum, prod_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

@@ design/mvst_ser_div.sv @@
// Restoring divider with a short quotient: one quotient bit per cycle, overflow flag.
module mvst_ser_div #(
	parameter int NUM_W = 54,
	parameter int DEN_W = 28,
	parameter int Q_W   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);

	localparam int HI_W  = NUM_W - Q_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   low_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [HI_W-1:0]  num_hi;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign num_hi = num[NUM_W-1:Q_W];
	assign trial  = {rem_q, low_q[Q_W-1]};
	assign diff   = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(Q_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// low_q shifts numerator bits out and quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			ovf_q <= (num_hi >= HI_W'(den));
			rem_q <= num_hi[DEN_W-1:0];
			low_q <= num[Q_W-1:0];
		end else if (run_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				low_q <= {low_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				low_q <= {low_q[Q_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = low_q;
	assign ovf  = ovf_q;

endmodule

@@ design/mppt_variable_step_tracker.sv @@
// Top level of the variable-step incremental-conductance MPPT tracker.
//
// One input beat (volt_mv, curr_ma, volt_floor_mv) on in_valid/in_stall gives
// exactly one output beat (setpoint_mv and the recorded peak) on
// out_valid/out_stall. Items are worked one at a time through bit-serial units:
// a shift-add multiplier forms P = V*I (with a second one forming
// resolution*|dV| alongside), a third multiplier forms gain*scaled|dP|, and a
// 16-bit restoring divider forms the step.
// A step is taken on a large power change, through the gain multiplier and
// the divider; the midpoint, peak and unchanged-voltage paths skip both.
// The next beat is taken in the cycle after the result is registered.
// A finished result sits in the output register; while out_stall holds it,
// the block may accept and work the next beat, and waits in its last step
// until the output register frees.
// Reset (arst_n low) clears the tracking state to zero, loads the register
// defaults and leaves both channels empty. Registers are written on cfg_wr_en
// and must only change while the block is idle.
module mppt_variable_step_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mvst_pkg::VOLT_W-1:0]     volt_mv,
	input  logic [mvst_pkg::CURR_W-1:0]     curr_ma,
	input  logic [mvst_pkg::VOLT_W-1:0]     volt_floor_mv,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mvst_pkg::VOLT_W-1:0]     setpoint_mv,
	output logic [mvst_pkg::PWR_W-1:0]      peak_power_uw,
	output logic [mvst_pkg::VOLT_W-1:0]     peak_volt_mv,
	output logic [mvst_pkg::CURR_W-1:0]     peak_curr_ma,
	input  logic                            cfg_wr_en,
	input  logic [mvst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mvst_pkg::CFG_W-1:0]      cfg_data
);

	import mvst_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL_P  = 3'd1;
	localparam logic [2:0] ST_DP     = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_MUL_G  = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0] state_q;

	// configuration
	logic [CFG_W-1:0] gain_base_q;
	logic [CFG_W-1:0] setpoint_max_q;
	logic [CFG_W-1:0] step_max_q;
	logic [CFG_W-1:0] slope_res_q;

	// tracking state
	logic [VOLT_W-1:0] prev_volt_q;
	logic [CURR_W-1:0] prev_curr_q;
	logic [PWR_W-1:0]  prev_pow_q;
	logic [VOLT_W-1:0] setpoint_q;
	logic [PWR_W-1:0]  best_power_q;
	logic [VOLT_W-1:0] best_volt_q;
	logic [CURR_W-1:0] best_curr_q;

	// per-item working registers
	logic [VOLT_W-1:0] volt_q;
	logic [CURR_W-1:0] curr_q;
	logic [VOLT_W-1:0] floor_q;
	logic              dv_nz_q;
	logic              dv_neg_q;
	logic [VOLT_W-1:0] dv_abs_q;
	logic [PWR_W-1:0]  p_now_q;
	logic [PWR_W-1:0]  r_prod_q;
	logic [PWR_W-1:0]  dp_abs_q;
	logic              dp_neg_q;
	logic [DEN_W-1:0]  den_q;
	logic              step_neg_q;
	logic signed [SP_W-1:0] sp_q;

	// output register
	logic              out_valid_q;
	logic [VOLT_W-1:0] out_sp_q;
	logic [PWR_W-1:0]  out_pwr_q;
	logic [VOLT_W-1:0] out_volt_q;
	logic [CURR_W-1:0] out_curr_q;

	logic in_beat;
	logic out_free;
	logic fin_write;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign fin_write = (state_q == ST_FIN) && out_free;

	// dV straight from the input port so the multipliers start on the accept edge
	logic [VOLT_W:0]   dv_full;
	logic [VOLT_W:0]   dv_mag;
	assign dv_full = {1'b0, volt_mv} - {1'b0, prev_volt_q};
	assign dv_mag  = dv_full[VOLT_W] ? (~dv_full + {{VOLT_W{1'b0}}, 1'b1}) : dv_full;

	// serial units
	logic                     p_done;
	logic [PWR_W-1:0]         p_prod;
	logic                     r_done;
	logic [PWR_W-1:0]         r_prod;
	logic                     g_done;
	logic [NUM_W-1:0]         g_prod;
	logic                     div_done;
	logic [QUO_W-1:0]         div_quo;
	logic                     div_ovf;
	logic [DPM_W-1:0]         dpm;
	logic                     big_dp;

	mvst_ser_mul #(.A_W(VOLT_W), .B_W(CURR_W)) u_mul_p (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_beat),
		.a      (volt_mv),
		.b      (curr_ma),
		.done   (p_done),
		.prod   (p_prod)
	);

	// slope resolution times |dV|, for the exact fine-slope test
	mvst_ser_mul #(.A_W(CFG_W), .B_W(VOLT_W)) u_mul_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_beat),
		.a      (slope_res_q),
		.b      (dv_mag[VOLT_W-1:0]),
		.done   (r_done),
		.prod   (r_prod)
	);

	// step numerator: gain_base * (|dP| * 40, 10 or 4)
	mvst_ser_mul #(.A_W(DPM_W), .B_W(CFG_W)) u_mul_g (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == ST_DECIDE) && dv_nz_q && big_dp),
		.a      (dpm),
		.b      (gain_base_q),
		.done   (g_done),
		.prod   (g_prod)
	);

	mvst_ser_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(QUO_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == ST_MUL_G) && g_done),
		.num    (g_prod),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo),
		.ovf    (div_ovf)
	);

	// dP from registered powers
	logic [PWR_W:0] dp_full;
	logic [PWR_W:0] dp_mag;
	assign dp_full = {1'b0, p_now_q} - {1'b0, prev_pow_q};
	assign dp_mag  = dp_full[PWR_W] ? (~dp_full + {{PWR_W{1'b0}}, 1'b1}) : dp_full;

	// decision terms
	logic coarse;
	logic pos_slope;
	logic [DPM_W-1:0] dp_ext;
	logic [DPM_W-1:0] dpm_a;
	logic [DPM_W-1:0] dpm_b;

	assign big_dp    = dp_abs_q > DP_THRESHOLD_UW;
	assign coarse    = dp_abs_q > r_prod_q;
	assign pos_slope = (dp_neg_q == dv_neg_q);
	assign dp_ext    = {{(DPM_W-PWR_W){1'b0}}, dp_abs_q};

	// gain multiples in units of 1/2560: 40 = 32 + 8, 10 = 8 + 2, 4
	always_comb begin
		if (coarse && pos_slope) begin
			dpm_a = dp_ext << 5;
			dpm_b = dp_ext << 3;
		end else if (coarse) begin
			dpm_a = dp_ext << 3;
			dpm_b = dp_ext << 1;
		end else begin
			dpm_a = dp_ext << 2;
			dpm_b = '0;
		end
	end
	assign dpm = dpm_a + dpm_b;

	// midpoint of old and new voltage
	logic [VOLT_W:0] mid_sum;
	assign mid_sum = {1'b0, volt_q} + {1'b0, prev_volt_q};

	// step magnitude saturated to step_max, then applied to the setpoint
	logic [CFG_W-1:0]       step_mag;
	logic signed [SP_W-1:0] sp_base;
	logic signed [SP_W-1:0] sp_delta;
	assign step_mag = (div_ovf || (div_quo > step_max_q)) ? step_max_q : div_quo;
	assign sp_base  = $signed({2'b00, setpoint_q});
	assign sp_delta = $signed({2'b00, step_mag});

	// clamp to maximum, then to floor (floor wins)
	logic signed [SP_W-1:0] sp_hi;
	logic signed [SP_W-1:0] sp_fin;
	always_comb begin
		sp_hi = sp_q;
		if (sp_q >= $signed({2'b00, setpoint_max_q})) begin
			sp_hi = $signed({2'b00, setpoint_max_q});
		end
		sp_fin = sp_hi;
		if (sp_hi <= $signed({2'b00, floor_q})) begin
			sp_fin = $signed({2'b00, floor_q});
		end
	end

	// control and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			gain_base_q    <= GAIN_BASE_RST;
			setpoint_max_q <= SETPOINT_MAX_RST;
			step_max_q     <= STEP_MAX_RST;
			slope_res_q    <= SLOPE_RES_RST;
			prev_volt_q    <= '0;
			prev_curr_q    <= '0;
			prev_pow_q     <= '0;
			setpoint_q     <= '0;
			best_power_q   <= '0;
			best_volt_q    <= '0;
			best_curr_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_GAIN_BASE:    gain_base_q    <= cfg_data;
					REG_SETPOINT_MAX: setpoint_max_q <= cfg_data;
					REG_STEP_MAX:     step_max_q     <= cfg_data;
					REG_SLOPE_RES:    slope_res_q    <= cfg_data;
					default: ;
				endcase
			end

			// beat leaves; a new result written this edge keeps it full
			if (out_valid_q && !out_stall && !fin_write) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_MUL_P;
					end
				end
				ST_MUL_P: begin
					if (p_done && r_done) begin
						state_q <= ST_DP;
					end
				end
				ST_DP: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (dv_nz_q && big_dp) begin
						state_q <= ST_MUL_G;
					end else begin
						// small power change or unchanged voltage: record the peak if the voltage moved
						if (dv_nz_q && (p_now_q > best_power_q)) begin
							best_power_q <= p_now_q;
							best_volt_q  <= volt_q;
							best_curr_q  <= curr_q;
						end
						state_q <= ST_FIN;
					end
				end
				ST_MUL_G: begin
					if (g_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						setpoint_q  <= sp_fin[VOLT_W-1:0];
						prev_volt_q <= volt_q;
						prev_curr_q <= curr_q;
						prev_pow_q  <= p_now_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			volt_q   <= volt_mv;
			curr_q   <= curr_ma;
			floor_q  <= volt_floor_mv;
			dv_nz_q  <= (dv_full != '0);
			dv_neg_q <= dv_full[VOLT_W];
			dv_abs_q <= dv_mag[VOLT_W-1:0];
		end
		if ((state_q == ST_MUL_P) && p_done && r_done) begin
			p_now_q  <= p_prod;
			r_prod_q <= r_prod;
		end
		if (state_q == ST_DP) begin
			dp_abs_q <= dp_mag[PWR_W-1:0];
			dp_neg_q <= dp_full[PWR_W];
		end
		if (state_q == ST_DECIDE) begin
			// |dV| * 2560 = |dV| * 2048 + |dV| * 512
			den_q      <= DEN_W'({dv_abs_q, 11'b0}) + DEN_W'({dv_abs_q, 9'b0});
			step_neg_q <= dp_neg_q ^ dv_neg_q;
			if (!dv_nz_q) begin
				sp_q <= sp_base;
			end else if (!big_dp) begin
				sp_q <= $signed({2'b00, mid_sum[VOLT_W:1]});
			end
		end
		if ((state_q == ST_DIV) && div_done) begin
			sp_q <= step_neg_q ? (sp_base - sp_delta) : (sp_base + sp_delta);
		end
		if (fin_write) begin
			out_sp_q   <= sp_fin[VOLT_W-1:0];
			out_pwr_q  <= best_power_q;
			out_volt_q <= best_volt_q;
			out_curr_q <= best_curr_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign setpoint_mv   = out_sp_q;
	assign peak_power_uw = out_pwr_q;
	assign peak_volt_mv  = out_volt_q;
	assign peak_curr_ma  = out_curr_q;

endmodule
